[design/mss_pkg.sv]
// package for the mean shift window step block
// constants, command codes and color bin helpers shared by all modules but mss_ram
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mss_pkg;

   localparam int MAX_PIX      = 4096;
   localparam int PIX_AW       = $clog2(MAX_PIX);
   localparam int CNT_BITS     = PIX_AW + 1;
   localparam int BINS         = 16;
   localparam int CBIN_BITS    = $clog2(BINS);
   localparam int HIST_DEPTH   = BINS * BINS * BINS;
   localparam int HIST_AW      = $clog2(HIST_DEPTH);
   localparam int HIST_BITS    = 28;
   localparam int W_BITS       = 16;
   localparam int SIZE_BITS    = 7;
   localparam int ORG_BITS     = 12;
   localparam int POS_BITS     = 14;
   localparam int COEF_BITS    = 17;
   localparam int COEF_MAX     = 65536;
   localparam int FRAC_BITS    = 16;
   localparam int PROD_BITS    = 2 * HIST_BITS;
   localparam int SUM_BITS     = HIST_BITS + HIST_AW;
   localparam int ROOT_BITS    = 32;
   localparam int SQW_BITS     = (HIST_BITS + FRAC_BITS) / 2;
   localparam int TERM_BITS    = SQW_BITS + W_BITS;
   localparam int ROW_BITS     = PIX_AW;
   localparam int COL_BITS     = SIZE_BITS - 1;
   localparam int ACC_BITS     = 64;
   localparam int DIV_BITS     = 64;
   localparam int PIXW_BITS    = HIST_AW + W_BITS;
   localparam int IN_BITS      = 40;
   localparam int OUT_BITS     = 48;
   localparam int PADDR_BITS   = 4;
   localparam int PDATA_BITS   = 32;

   localparam logic CMD_MODEL = 1'b0;
   localparam logic CMD_CAND  = 1'b1;

   localparam logic [1:0] REG_ROWS    = 2'd0;
   localparam logic [1:0] REG_COLS    = 2'd1;
   localparam logic [1:0] REG_ORG_ROW = 2'd2;
   localparam logic [1:0] REG_ORG_COL = 2'd3;

   function automatic logic [CBIN_BITS-1:0] color_bin(input logic [7:0] c);
      int t;
      t = int'(c) * BINS;
      return CBIN_BITS'(t >> 8);
   endfunction

   function automatic logic [HIST_AW-1:0] bin_index(input logic [7:0] b,
                                                    input logic [7:0] g,
                                                    input logic [7:0] r);
      int t;
      t = (int'(color_bin(b)) * BINS + int'(color_bin(g))) * BINS + int'(color_bin(r));
      return HIST_AW'(t);
   endfunction

endpackage
`default_nettype wire

[design/mss_ram.sv]
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module mss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule
`default_nettype wire

[design/mss_div.sv]
// restoring divider, one quotient bit per cycle
// depends on mss_pkg
`timescale 1ns / 1ps
`default_nettype none
module mss_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [mss_pkg::DIV_BITS-1:0] num,
   input  wire logic [mss_pkg::DIV_BITS-1:0] den,
   output logic                              done,
   output logic      [mss_pkg::DIV_BITS-1:0] quot
);
   import mss_pkg::*;

   localparam int CW = $clog2(DIV_BITS);

   logic [DIV_BITS-1:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [DIV_BITS:0]   trial, diff;
   logic                ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_BITS-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
         quo_in = {quo_ff[DIV_BITS-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule
`default_nettype wire

[design/mss_isqrt.sv]
// floor square root, one result bit per cycle
// depends on mss_pkg
`timescale 1ns / 1ps
`default_nettype none
module mss_isqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [mss_pkg::DIV_BITS-1:0]  arg,
   output logic                               done,
   output logic      [mss_pkg::ROOT_BITS-1:0] root
);
   import mss_pkg::*;

   logic [DIV_BITS-1:0] v_ff, v_in, res_ff, res_in, bit_ff, bit_in, sum;
   logic                busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      sum     = res_ff + bit_ff;
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in    = arg;
         res_in  = '0;
         bit_in  = DIV_BITS'(1) << (DIV_BITS - 2);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= sum) begin
            v_in   = v_ff - sum;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_BITS-1:0];

endmodule
`default_nettype wire

[design/mean_shift_window_step.sv]
// mean shift window step: color histograms, coefficient and centroid sequencer
// depends on mss_pkg, mss_ram, mss_div, mss_isqrt
//
// usage:
//   req_ stream carries window pixels in row-major order; tuser is the pass
//   (0 model, 1 candidate), tlast closes the pass; each pixel is stored before the next is taken.
//   rsp_ stream gives one word per tlast: the model pass gives a word of
//   zeros with tuser 0; the candidate pass gives coefficient and new position.
//   csr_ port holds window size and origin; write it only while idle.
//   after reset both histograms are cleared, with req_tready low meanwhile.
//   the first model pixel after a finished model clears the model before it is taken.
//   candidate finishing: per bin a read, a multiply and, when the product is
//   nonzero, a square root on the shared square root unit; per stored pixel a
//   divide and a square root, skipped when its bin is empty; two divisions for
//   the position unless no weight was summed; then a candidate histogram clear.
//   a result sits in the output register until taken; the block keeps going
//   and stalls only when a second result is ready before the first is taken.
`timescale 1ns / 1ps
`default_nettype none
module mean_shift_window_step (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [mss_pkg::IN_BITS-1:0]    req_tdata,  // blue, green, red, kernel_weight
   input  wire logic                           req_tuser,  // cmd
   input  wire logic                           req_tlast,  // last
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [mss_pkg::OUT_BITS-1:0]   rsp_tdata,  // coefficient, new_row, new_col, no_weight
   output logic                                rsp_tuser,  // kind
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [mss_pkg::PADDR_BITS-1:0] csr_paddr,
   input  wire logic [mss_pkg::PDATA_BITS-1:0] csr_pwdata,
   output logic      [mss_pkg::PDATA_BITS-1:0] csr_prdata,
   output logic                                csr_pready
);
   import mss_pkg::*;

   localparam logic [4:0] S_CLEAR     = 5'd0;
   localparam logic [4:0] S_IDLE      = 5'd1;
   localparam logic [4:0] S_UPD       = 5'd2;
   localparam logic [4:0] S_SUM_RD    = 5'd3;
   localparam logic [4:0] S_SUM_MUL   = 5'd4;
   localparam logic [4:0] S_SUM_SQ    = 5'd5;
   localparam logic [4:0] S_SUM_SQW   = 5'd6;
   localparam logic [4:0] S_TOT_MUL   = 5'd7;
   localparam logic [4:0] S_TOT_SQ    = 5'd8;
   localparam logic [4:0] S_TOT_SQW   = 5'd9;
   localparam logic [4:0] S_COEF_DIVW = 5'd10;
   localparam logic [4:0] S_PIX_RD    = 5'd11;
   localparam logic [4:0] S_PIX_HRD   = 5'd12;
   localparam logic [4:0] S_PIX_CHK   = 5'd13;
   localparam logic [4:0] S_PIX_DIVW  = 5'd14;
   localparam logic [4:0] S_PIX_SQW   = 5'd15;
   localparam logic [4:0] S_PIX_MUL   = 5'd16;
   localparam logic [4:0] S_PIX_ACC1  = 5'd17;
   localparam logic [4:0] S_PIX_ACC2  = 5'd18;
   localparam logic [4:0] S_POS       = 5'd19;
   localparam logic [4:0] S_POS_RW    = 5'd20;
   localparam logic [4:0] S_POS_CW    = 5'd21;
   localparam logic [4:0] S_EMIT      = 5'd22;

   localparam int RES_BITS = COEF_BITS + 2 * POS_BITS + 1;

   // configuration
   logic [SIZE_BITS-1:0] rows_ff, rows_in, cols_ff, cols_in, rows_c, cols_c;
   logic [ORG_BITS-1:0]  orow_ff, orow_in, ocol_ff, ocol_in;
   logic                 csr_wr;

   // sequencer
   logic [4:0]            state_ff, state_in;
   logic                  cmd_ff, cmd_in, last_ff, last_in;
   logic [HIST_AW-1:0]    bin_ff, bin_in, clr_ff, clr_in, h_ff, h_in;
   logic [W_BITS-1:0]     kw_ff, kw_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [HIST_BITS-1:0]  mtot_ff, mtot_in, ctot_ff, ctot_in;
   logic                  mdone_ff, mdone_in, clr_m_ff, clr_m_in, clr_c_ff, clr_c_in;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;
   logic [SUM_BITS-1:0]   s_ff, s_in;
   logic [COEF_BITS-1:0]  coef_ff, coef_in;
   logic [PIX_AW-1:0]     p_ff, p_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [COL_BITS-1:0]   col_ff, col_in;
   logic [SQW_BITS-1:0]   w_ff, w_in;
   logic [TERM_BITS-1:0]  term_ff, term_in;
   logic [ROW_BITS+TERM_BITS-1:0] mr_ff, mr_in;
   logic [COL_BITS+TERM_BITS-1:0] mc_ff, mc_in;
   logic [ACC_BITS-1:0]   de_ff, de_in, ner_ff, ner_in, nec_ff, nec_in;
   logic [POS_BITS-1:0]   qr_ff, qr_in, nr_ff, nr_in, nc_ff, nc_in;
   logic                  flag_ff, flag_in;
   logic                  rsp_valid_ff, rsp_valid_in, rsp_kind_ff, rsp_kind_in;
   logic [RES_BITS-1:0]   rsp_data_ff, rsp_data_in;
   logic                  fin_go, pix_go;

   // datapath wiring
   logic [HIST_AW-1:0]   in_bin, hist_raddr, hist_waddr;
   logic [HIST_BITS-1:0] model_rd, cand_rd, model_wd, cand_wd;
   logic                 model_we, cand_we, pix_we;
   logic [PIXW_BITS-1:0] pix_rd;
   logic                 sq_go, sq_done, dv_go, dv_done;
   logic [DIV_BITS-1:0]  sq_arg, dv_num, dv_den, dv_quot;
   logic [ROOT_BITS-1:0] sq_root;

   assign in_bin = bin_index(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]);

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      orow_in = orow_ff;
      ocol_in = ocol_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_ROWS:    rows_in = csr_pwdata[SIZE_BITS-1:0];
            REG_COLS:    cols_in = csr_pwdata[SIZE_BITS-1:0];
            REG_ORG_ROW: orow_in = csr_pwdata[ORG_BITS-1:0];
            REG_ORG_COL: ocol_in = csr_pwdata[ORG_BITS-1:0];
            default:     rows_in = rows_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_ROWS:    csr_prdata = PDATA_BITS'(rows_ff);
         REG_COLS:    csr_prdata = PDATA_BITS'(cols_ff);
         REG_ORG_ROW: csr_prdata = PDATA_BITS'(orow_ff);
         REG_ORG_COL: csr_prdata = PDATA_BITS'(ocol_ff);
         default:     csr_prdata = '0;
      endcase
   end

   assign rows_c = (rows_ff == '0) ? SIZE_BITS'(1) :
                   (rows_ff > SIZE_BITS'(64)) ? SIZE_BITS'(64) : rows_ff;
   assign cols_c = (cols_ff == '0) ? SIZE_BITS'(1) :
                   (cols_ff > SIZE_BITS'(64)) ? SIZE_BITS'(64) : cols_ff;

   // histogram and pixel store write side
   assign model_we   = (state_ff == S_CLEAR && clr_m_ff) ||
                       (state_ff == S_UPD && cmd_ff == CMD_MODEL);
   assign cand_we    = (state_ff == S_CLEAR && clr_c_ff) ||
                       (state_ff == S_UPD && cmd_ff == CMD_CAND);
   assign hist_waddr = (state_ff == S_CLEAR) ? clr_ff : bin_ff;
   assign model_wd   = (state_ff == S_CLEAR) ? '0 : model_rd + HIST_BITS'(kw_ff);
   assign cand_wd    = (state_ff == S_CLEAR) ? '0 : cand_rd + HIST_BITS'(kw_ff);
   assign pix_we     = (state_ff == S_UPD && cmd_ff == CMD_CAND);

   assign req_tready = (state_ff == S_IDLE) && !(req_tuser == CMD_MODEL && mdone_ff);

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      last_in  = last_ff;
      bin_in   = bin_ff;
      kw_in    = kw_ff;
      cnt_in   = cnt_ff;
      mtot_in  = mtot_ff;
      ctot_in  = ctot_ff;
      mdone_in = mdone_ff;
      clr_in   = clr_ff;
      clr_m_in = clr_m_ff;
      clr_c_in = clr_c_ff;
      h_in     = h_ff;
      prod_in  = prod_ff;
      s_in     = s_ff;
      coef_in  = coef_ff;
      p_in     = p_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      w_in     = w_ff;
      term_in  = term_ff;
      mr_in    = mr_ff;
      mc_in    = mc_ff;
      de_in    = de_ff;
      ner_in   = ner_ff;
      nec_in   = nec_ff;
      qr_in    = qr_ff;
      nr_in    = nr_ff;
      nc_in    = nc_ff;
      flag_in  = flag_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      fin_go     = 1'b0;
      pix_go     = 1'b0;
      sq_go      = 1'b0;
      dv_go      = 1'b0;
      hist_raddr = h_ff;
      sq_arg     = DIV_BITS'(prod_ff);
      dv_num     = ner_ff;
      dv_den     = de_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == HIST_AW'(HIST_DEPTH - 1)) begin
               clr_m_in = 1'b0;
               clr_c_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            hist_raddr = in_bin;
            if (req_tvalid && req_tuser == CMD_MODEL && mdone_ff) begin
               clr_m_in = 1'b1;
               clr_in   = '0;
               mtot_in  = '0;
               mdone_in = 1'b0;
               state_in = S_CLEAR;
            end else if (req_tvalid) begin
               cmd_in  = req_tuser;
               last_in = req_tlast;
               bin_in  = in_bin;
               kw_in   = req_tdata[39:24];
               if (req_tuser == CMD_MODEL || cnt_ff < CNT_BITS'(MAX_PIX)) begin
                  state_in = S_UPD;
               end else if (req_tlast) begin
                  fin_go = 1'b1;
               end
            end
         end
         S_UPD: begin
            if (cmd_ff == CMD_MODEL) begin
               mtot_in = mtot_ff + HIST_BITS'(kw_ff);
            end else begin
               ctot_in = ctot_ff + HIST_BITS'(kw_ff);
               cnt_in  = cnt_ff + 1'b1;
            end
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (cmd_ff == CMD_MODEL) begin
               mdone_in = 1'b1;
               state_in = S_EMIT;
            end else begin
               fin_go = 1'b1;
            end
         end
         S_SUM_RD: begin
            state_in = S_SUM_MUL;
         end
         S_SUM_MUL: begin
            prod_in  = PROD_BITS'(cand_rd) * PROD_BITS'(model_rd);
            state_in = S_SUM_SQ;
         end
         S_SUM_SQ, S_SUM_SQW: begin
            if (state_ff == S_SUM_SQ && prod_ff != '0) begin
               sq_go    = 1'b1;
               state_in = S_SUM_SQW;
            end else if (state_ff == S_SUM_SQ || sq_done) begin
               if (state_ff == S_SUM_SQW) begin
                  s_in = s_ff + SUM_BITS'(sq_root);
               end
               h_in = h_ff + 1'b1;
               state_in = (h_ff == HIST_AW'(HIST_DEPTH - 1)) ? S_TOT_MUL : S_SUM_RD;
            end
         end
         S_TOT_MUL: begin
            prod_in  = PROD_BITS'(ctot_ff) * PROD_BITS'(mtot_ff);
            state_in = S_TOT_SQ;
         end
         S_TOT_SQ: begin
            if (prod_ff == '0) begin
               pix_go = 1'b1;
            end else begin
               sq_go    = 1'b1;
               state_in = S_TOT_SQW;
            end
         end
         S_TOT_SQW: begin
            dv_num = DIV_BITS'(s_ff) << FRAC_BITS;
            dv_den = DIV_BITS'(sq_root);
            if (sq_done) begin
               dv_go    = 1'b1;
               state_in = S_COEF_DIVW;
            end
         end
         S_COEF_DIVW: begin
            if (dv_done) begin
               coef_in = (dv_quot > DIV_BITS'(COEF_MAX)) ? COEF_BITS'(COEF_MAX)
                                                         : dv_quot[COEF_BITS-1:0];
               pix_go = 1'b1;
            end
         end
         S_PIX_RD: begin
            state_in = S_PIX_HRD;
         end
         S_PIX_HRD: begin
            hist_raddr = pix_rd[HIST_AW-1:0];
            kw_in      = pix_rd[PIXW_BITS-1:HIST_AW];
            state_in   = S_PIX_CHK;
         end
         S_PIX_CHK: begin
            dv_num = DIV_BITS'(model_rd) << FRAC_BITS;
            dv_den = DIV_BITS'(cand_rd);
            if (cand_rd == '0) begin
               w_in     = '0;
               state_in = S_PIX_MUL;
            end else begin
               dv_go    = 1'b1;
               state_in = S_PIX_DIVW;
            end
         end
         S_PIX_DIVW: begin
            sq_arg = dv_quot;
            if (dv_done) begin
               sq_go    = 1'b1;
               state_in = S_PIX_SQW;
            end
         end
         S_PIX_SQW: begin
            if (sq_done) begin
               w_in     = sq_root[SQW_BITS-1:0];
               state_in = S_PIX_MUL;
            end
         end
         S_PIX_MUL: begin
            term_in  = TERM_BITS'(w_ff) * TERM_BITS'(kw_ff);
            state_in = S_PIX_ACC1;
         end
         S_PIX_ACC1: begin
            de_in    = de_ff + ACC_BITS'(term_ff);
            mr_in    = (ROW_BITS + TERM_BITS)'(row_ff) * (ROW_BITS + TERM_BITS)'(term_ff);
            mc_in    = (COL_BITS + TERM_BITS)'(col_ff) * (COL_BITS + TERM_BITS)'(term_ff);
            state_in = S_PIX_ACC2;
         end
         S_PIX_ACC2: begin
            ner_in = ner_ff + ACC_BITS'(mr_ff);
            nec_in = nec_ff + ACC_BITS'(mc_ff);
            if ({1'b0, p_ff} == cnt_ff - 1'b1) begin
               state_in = S_POS;
            end else begin
               p_in = p_ff + 1'b1;
               if ({1'b0, col_ff} + SIZE_BITS'(1) == cols_c) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
               state_in = S_PIX_RD;
            end
         end
         S_POS: begin
            if (de_ff == '0) begin
               flag_in  = 1'b1;
               nr_in    = POS_BITS'(orow_ff);
               nc_in    = POS_BITS'(ocol_ff);
               state_in = S_EMIT;
            end else begin
               dv_go    = 1'b1;
               state_in = S_POS_RW;
            end
         end
         S_POS_RW: begin
            dv_num = nec_ff;
            if (dv_done) begin
               qr_in    = dv_quot[POS_BITS-1:0];
               dv_go    = 1'b1;
               state_in = S_POS_CW;
            end
         end
         S_POS_CW: begin
            if (dv_done) begin
               nr_in = POS_BITS'(orow_ff) + qr_ff - POS_BITS'(rows_c >> 1);
               nc_in = POS_BITS'(ocol_ff) + dv_quot[POS_BITS-1:0] - POS_BITS'(cols_c >> 1);
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = cmd_ff;
               rsp_data_in  = (cmd_ff == CMD_CAND) ? {flag_ff, nc_ff, nr_ff, coef_ff} : '0;
               if (cmd_ff == CMD_CAND) begin
                  clr_c_in = 1'b1;
                  clr_in   = '0;
                  ctot_in  = '0;
                  cnt_in   = '0;
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (fin_go) begin
         state_in = S_SUM_RD;
         h_in     = '0;
         s_in     = '0;
         coef_in  = '0;
         p_in     = '0;
         row_in   = '0;
         col_in   = '0;
         de_in    = '0;
         ner_in   = '0;
         nec_in   = '0;
         flag_in  = 1'b0;
      end
      if (pix_go) begin
         state_in = (cnt_ff == '0) ? S_POS : S_PIX_RD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= SIZE_BITS'(40);
         cols_ff      <= SIZE_BITS'(30);
         orow_ff      <= '0;
         ocol_ff      <= '0;
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         clr_m_ff     <= 1'b1;
         clr_c_ff     <= 1'b1;
         cnt_ff       <= '0;
         mtot_ff      <= '0;
         ctot_ff      <= '0;
         mdone_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         orow_ff      <= orow_in;
         ocol_ff      <= ocol_in;
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_m_ff     <= clr_m_in;
         clr_c_ff     <= clr_c_in;
         cnt_ff       <= cnt_in;
         mtot_ff      <= mtot_in;
         ctot_ff      <= ctot_in;
         mdone_ff     <= mdone_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      last_ff     <= last_in;
      bin_ff      <= bin_in;
      kw_ff       <= kw_in;
      h_ff        <= h_in;
      prod_ff     <= prod_in;
      s_ff        <= s_in;
      coef_ff     <= coef_in;
      p_ff        <= p_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      w_ff        <= w_in;
      term_ff     <= term_in;
      mr_ff       <= mr_in;
      mc_ff       <= mc_in;
      de_ff       <= de_in;
      ner_ff      <= ner_in;
      nec_ff      <= nec_in;
      qr_ff       <= qr_in;
      nr_ff       <= nr_in;
      nc_ff       <= nc_in;
      flag_ff     <= flag_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = OUT_BITS'(rsp_data_ff);

   mss_ram #(.WIDTH(HIST_BITS), .DEPTH(HIST_DEPTH)) u_model_hist (
      .clock   (clock),
      .wr_en   (model_we),
      .wr_addr (hist_waddr),
      .wr_data (model_wd),
      .rd_addr (hist_raddr),
      .rd_data (model_rd)
   );

   mss_ram #(.WIDTH(HIST_BITS), .DEPTH(HIST_DEPTH)) u_cand_hist (
      .clock   (clock),
      .wr_en   (cand_we),
      .wr_addr (hist_waddr),
      .wr_data (cand_wd),
      .rd_addr (hist_raddr),
      .rd_data (cand_rd)
   );

   mss_ram #(.WIDTH(PIXW_BITS), .DEPTH(MAX_PIX)) u_pixel_store (
      .clock   (clock),
      .wr_en   (pix_we),
      .wr_addr (cnt_ff[PIX_AW-1:0]),
      .wr_data ({kw_ff, bin_ff}),
      .rd_addr (p_ff),
      .rd_data (pix_rd)
   );

   mss_div u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_go),
      .num   (dv_num),
      .den   (dv_den),
      .done  (dv_done),
      .quot  (dv_quot)
   );

   mss_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_go),
      .arg   (sq_arg),
      .done  (sq_done),
      .root  (sq_root)
   );

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(MAX_PIX))
      else $error("pixel count beyond store depth");

   a_model_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == CMD_MODEL |-> rsp_tdata == '0)
      else $error("model word carries data");

   a_coef_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[COEF_BITS-1:0] <= COEF_BITS'(COEF_MAX))
      else $error("coefficient above saturation");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE && !clr_m_ff && !clr_c_ff)
      else $error("ready outside idle");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> state_ff == S_CLEAR && !rsp_tvalid)
      else $error("reset did not start clearing");

endmodule
`default_nettype wire

[test/testbench.sv]
// self-checking testbench for mean_shift_window_step: model and candidate pixel
// passes, checked against a behavioral histogram and centroid predictor
// depends on mss_pkg and the design files
`timescale 1ns / 1ps
module testbench;
   import mss_pkg::*;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [15:0] kw;
      logic        last;
   } pixel_type;

   typedef struct packed {
      logic        kind;
      logic [16:0] coef;
      logic [13:0] row;
      logic [13:0] col;
      logic        no_weight;
   } step_type;

   typedef struct packed {
      pixel_type px;
      logic      typed;
      step_type  want;
   } row_type;

   logic clock, reset;
   logic req_tvalid, req_tready, req_tuser, req_tlast;
   logic [IN_BITS-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready, rsp_tuser;
   logic [OUT_BITS-1:0] rsp_tdata;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [PADDR_BITS-1:0] csr_paddr;
   logic [PDATA_BITS-1:0] csr_pwdata, csr_prdata;

   mean_shift_window_step dut (.*);

   // predictor state
   longint unsigned model_hist [HIST_DEPTH];
   longint unsigned cand_hist [HIST_DEPTH];
   int unsigned     pix_bin [MAX_PIX];
   int unsigned     pix_wt [MAX_PIX];
   int unsigned     pix_cnt;
   longint unsigned model_sum, cand_sum;
   bit              model_done;
   longint unsigned win_rows, win_cols, org_row, org_col;

   step_type steps_due [$];
   int    mismatches, results_seen, pixels_sent, passes_sent, phases_run;
   int    burst_left;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #500ms;
      $display("timeout with %0d results outstanding", steps_due.size());
      $display("FAIL mean_shift_window_step");
      $finish;
   end

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic int unsigned hist_bin(pixel_type p);
      return ((int'(p.blue) >> 4) * 16 + (int'(p.green) >> 4)) * 16 + (int'(p.red) >> 4);
   endfunction

   function automatic longint unsigned size_sat(longint unsigned v);
      return (v < 1) ? 1 : (v > 64) ? 64 : v;
   endfunction

   // returns 1 when the pixel closes a pass
   function automatic bit track_pixel(pixel_type p, output step_type r);
      int unsigned b;
      longint unsigned s, d, coef, de, ne_r, ne_c, rows, cols, w, term, nr, nc;
      b = hist_bin(p);
      r = '0;
      if (p.cmd == CMD_MODEL) begin
         if (model_done) begin
            foreach (model_hist[i]) model_hist[i] = 0;
            model_sum = 0;
            model_done = 0;
         end
         model_hist[b] = (model_hist[b] + p.kw) & 64'hFFFFFFF;
         model_sum = (model_sum + p.kw) & 64'hFFFFFFF;
         if (!p.last) return 0;
         model_done = 1;
         return 1;
      end
      if (pix_cnt < MAX_PIX) begin
         cand_hist[b] = (cand_hist[b] + p.kw) & 64'hFFFFFFF;
         cand_sum = (cand_sum + p.kw) & 64'hFFFFFFF;
         pix_bin[pix_cnt] = b;
         pix_wt[pix_cnt] = p.kw;
         pix_cnt++;
      end
      if (!p.last) return 0;
      s = 0;
      for (int h = 0; h < HIST_DEPTH; h++) s += root_floor(cand_hist[h] * model_hist[h]);
      d = root_floor(cand_sum * model_sum);
      coef = 0;
      if (d != 0) begin
         coef = (s << 16) / d;
         if (coef > COEF_MAX) coef = COEF_MAX;
      end
      rows = size_sat(win_rows);
      cols = size_sat(win_cols);
      de = 0; ne_r = 0; ne_c = 0;
      for (int unsigned i = 0; i < pix_cnt; i++) begin
         w = 0;
         if (cand_hist[pix_bin[i]] != 0)
            w = root_floor((model_hist[pix_bin[i]] << 16) / cand_hist[pix_bin[i]]);
         term = w * pix_wt[i];
         de += term;
         ne_r += (i / cols) * term;
         ne_c += (i % cols) * term;
      end
      r.kind = 1'b1;
      r.coef = coef[16:0];
      if (de == 0) begin
         nr = org_row;
         nc = org_col;
         r.no_weight = 1'b1;
      end else begin
         nr = org_row + ne_r / de - rows / 2;
         nc = org_col + ne_c / de - cols / 2;
      end
      r.row = nr[13:0];
      r.col = nc[13:0];
      foreach (cand_hist[i]) cand_hist[i] = 0;
      cand_sum = 0;
      pix_cnt = 0;
      return 1;
   endfunction

   task automatic push_pixel(pixel_type p, bit typed, step_type want);
      step_type r;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= p.cmd;
      req_tlast  <= p.last;
      req_tdata  <= {p.kw, p.red, p.green, p.blue};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
      if (track_pixel(p, r)) begin
         steps_due.push_back(typed ? want : r);
         passes_sent++;
      end
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      req_tvalid <= 1'b0;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= PADDR_BITS'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_ROWS:    win_rows = value & 32'h7F;
         REG_COLS:    win_cols = value & 32'h7F;
         REG_ORG_ROW: org_row  = value & 32'hFFF;
         REG_ORG_COL: org_col  = value & 32'hFFF;
         default:     ;
      endcase
   endtask

   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (steps_due.size() != 0) @(posedge clock);
      repeat (5000) @(posedge clock);
   endtask

   // receiver stall pattern: ready rate is redrawn whenever the random stall span runs out
   int ready_pct, stall_span;
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_span <= $urandom_range(50, 400);
         case ($urandom_range(0, 3))
            0: ready_pct <= 100;
            1: ready_pct <= 60;
            2: ready_pct <= 20;
            default: ready_pct <= 3;
         endcase
      end else begin
         stall_span <= stall_span - 1;
      end
      rsp_tready <= ($urandom_range(0, 99) < ready_pct);
   end

   always @(posedge clock) begin
      step_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{kind: rsp_tuser, coef: rsp_tdata[16:0], row: rsp_tdata[30:17],
                 col: rsp_tdata[44:31], no_weight: rsp_tdata[45]};
         results_seen++;
         if (steps_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h kind %b", rsp_tdata, rsp_tuser);
         end else begin
            want = steps_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("word %0d: exp kind %b coef %0d row %0d col %0d nw %b",
                           results_seen, want.kind, want.coef, $signed(want.row),
                           $signed(want.col), want.no_weight);
                  $display("         got kind %b coef %0d row %0d col %0d nw %b",
                           got.kind, got.coef, $signed(got.row), $signed(got.col),
                           got.no_weight);
               end
            end
         end
      end
   end

   function automatic row_type mk(logic cmd, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                  logic [15:0] kw, logic last, logic typed, logic kind,
                                  logic no_weight);
      row_type t;
      t.px = '{cmd: cmd, blue: b, green: g, red: r, kw: kw, last: last};
      t.typed = typed;
      t.want = '{kind: kind, coef: 17'd0, row: 14'd0, col: 14'd0, no_weight: no_weight};
      return t;
   endfunction

   row_type directed [$];
   logic [23:0] palette [8];
   int unsigned cfg [6][4];

   initial begin
      pixel_type p;
      int len;
      reset = 1'b1;
      req_tvalid = 0; req_tuser = 0; req_tlast = 0; req_tdata = '0;
      rsp_tready = 0; ready_pct = 100; stall_span = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      foreach (model_hist[i]) begin
         model_hist[i] = 0;
         cand_hist[i] = 0;
      end
      pix_cnt = 0; model_sum = 0; cand_sum = 0; model_done = 0;
      win_rows = 40; win_cols = 30; org_row = 0; org_col = 0;
      mismatches = 0; results_seen = 0; pixels_sent = 0; passes_sent = 0; phases_run = 0;
      burst_left = 0;

      // directed rows at reset configuration
      directed.push_back(mk(CMD_MODEL, 8'd0,   8'd0,   8'd0,   16'hFFFF, 0, 0, 0, 0));
      directed.push_back(mk(CMD_MODEL, 8'd255, 8'd255, 8'd255, 16'h0000, 0, 0, 0, 0));
      directed.push_back(mk(CMD_MODEL, 8'd255, 8'd0,   8'd128, 16'h0001, 1, 1, 0, 0));
      directed.push_back(mk(CMD_CAND,  8'd0,   8'd0,   8'd0,   16'hFFFF, 0, 0, 0, 0));
      directed.push_back(mk(CMD_CAND,  8'd255, 8'd255, 8'd255, 16'hFFFF, 0, 0, 0, 0));
      directed.push_back(mk(CMD_CAND,  8'd15,  8'd16,  8'd240, 16'h8000, 0, 0, 0, 0));
      directed.push_back(mk(CMD_CAND,  8'd255, 8'd0,   8'd128, 16'd30000, 1, 0, 0, 0));
      // zero kernel weights: zero totals and zero denominator
      directed.push_back(mk(CMD_CAND,  8'd17,  8'd34,  8'd51,  16'h0000, 1, 1, 1, 1));
      directed.push_back(mk(CMD_MODEL, 8'd8,   8'd8,   8'd8,   16'd100,  1, 1, 0, 0));
      // colors absent from the model
      directed.push_back(mk(CMD_CAND,  8'd200, 8'd100, 8'd50,  16'd500,  1, 1, 1, 1));
      // model pixel inside a candidate pass restarts the model
      directed.push_back(mk(CMD_CAND,  8'd8,   8'd8,   8'd8,   16'd700,  0, 0, 0, 0));
      directed.push_back(mk(CMD_MODEL, 8'd8,   8'd9,   8'd8,   16'd300,  0, 0, 0, 0));
      directed.push_back(mk(CMD_CAND,  8'd0,   8'd0,   8'd0,   16'd900,  0, 0, 0, 0));
      directed.push_back(mk(CMD_CAND,  8'd8,   8'd8,   8'd8,   16'hFFFF, 1, 0, 0, 0));
      directed.push_back(mk(CMD_MODEL, 8'd1,   8'd2,   8'd3,   16'hFFFF, 1, 1, 0, 0));
      for (int i = 0; i < 9; i++)
         directed.push_back(mk(CMD_CAND, 8'd1, 8'(i * 30), 8'd3, 16'(i * 8000 + 1), i == 8,
                               0, 0, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) push_pixel(directed[i].px, directed[i].typed, directed[i].want);
      drain_and_settle();

      cfg = '{'{1, 1, 0, 0}, '{64, 64, 4095, 4095}, '{0, 127, 4095, 0},
              '{5, 3, 100, 200}, '{127, 0, 0, 4095}, '{0, 0, 0, 0}};
      cfg[5] = '{$urandom_range(0, 127), $urandom_range(0, 127),
                 $urandom_range(0, 4095), $urandom_range(0, 4095)};
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(REG_ROWS, cfg[ph][0]);
         write_reg(REG_COLS, cfg[ph][1]);
         write_reg(REG_ORG_ROW, cfg[ph][2]);
         write_reg(REG_ORG_COL, cfg[ph][3]);
         phases_run++;
         foreach (palette[i]) palette[i] = 24'($urandom);
         while (pixels_sent < directed.size() + (ph + 1) * 125) begin
            // new model now and then, otherwise candidate passes against it
            p.cmd = ($urandom_range(0, 3) == 0) ? CMD_MODEL : CMD_CAND;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 25);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 4) == 0)
                  {p.red, p.green, p.blue} = 24'($urandom);
               else
                  {p.red, p.green, p.blue} = palette[$urandom_range(0, 7)];
               case ($urandom_range(0, 9))
                  0: p.kw = 16'h0000;
                  1: p.kw = 16'hFFFF;
                  default: p.kw = 16'($urandom);
               endcase
               p.last = (k == len - 1);
               // noise: a stray pixel of the other kind
               if (!p.last && $urandom_range(0, 40) == 0) begin
                  p.cmd = ~p.cmd;
                  push_pixel(p, 0, '0);
                  p.cmd = ~p.cmd;
               end else begin
                  push_pixel(p, 0, '0);
               end
            end
         end
         drain_and_settle();
      end

      $display("sent %0d pixels in %0d passes over %0d register settings", pixels_sent,
               passes_sent, phases_run);
      $display("checked %0d result words, %0d mismatches", results_seen, mismatches);
      if (mismatches == 0 && steps_due.size() == 0) begin
         $display("PASS mean_shift_window_step");
      end else begin
         $display("FAIL mean_shift_window_step");
      end
      $finish;
   end
endmodule
